FILE: hdl/spifr_pkg.sv
package spifr_pkg;

  // Item field widths
  localparam int ADDR_W = 24;
  localparam int LEN_W  = 8;
  localparam int BYTE_W = 8;

  // Default width of the address sent after the opcode
  localparam int ADDR_BITS_DEF = 24;

  // Serial flash READ opcode
  localparam logic [7:0] READ_OPCODE = 8'h03;

  // Half period register
  localparam int          HALF_W     = 5;
  localparam int          TICK_W     = 4;
  localparam logic [4:0]  HALF_RESET = 5'd2;
  localparam logic [4:0]  HALF_MIN   = 5'd1;
  localparam logic [4:0]  HALF_MAX   = 5'd16;

  // Configuration port
  localparam int         PADDR_W         = 3;
  localparam int         PDATA_W         = 32;
  localparam logic [0:0] REG_HALF_PERIOD = 1'b0;

  // Transaction phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

endpackage

FILE: hdl/spifr_if.sv
// One tick of the bit sequencer: start request and sampled pin level
interface spifr_tick_if;
  logic                       valid;
  logic                       ready;
  logic                       start_req;
  logic [spifr_pkg::ADDR_W-1:0] address;
  logic [spifr_pkg::LEN_W-1:0]  length;
  logic                       miso;

  modport source (output valid, start_req, address, length, miso, input ready);
  modport sink   (input valid, start_req, address, length, miso, output ready);
endinterface

// Pin levels and received byte for one tick
interface spifr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        cs_n;
  logic                        sclk;
  logic                        mosi;
  logic                        byte_valid;
  logic [spifr_pkg::BYTE_W-1:0] read_byte;
  logic                        last_byte;
  logic                        busy_res;

  modport source (output valid, cs_n, sclk, mosi, byte_valid, read_byte, last_byte,
                  busy_res, input ready);
  modport sink   (input valid, cs_n, sclk, mosi, byte_valid, read_byte, last_byte,
                  busy_res, output ready);
endinterface

FILE: hdl/spi_flash_read_master.sv
// Channel  Dir  Handshake      Payload
// -------  ---  -------------  ------------------------------------------------
// tick     in   valid / ready  start_req, address[23:0], length[7:0], miso
// result   out  valid / ready  cs_n, sclk, mosi, byte_valid, read_byte[7:0],
//                              last_byte, busy_res
// cfg      in   APB write/read half_period_ticks at byte address 0
//
// One tick item is taken per cycle; its result item is registered and shows
// in the next cycle, held in one result register; the phase, shift and count
// registers hold the sequencer. Reset (rst, synchronous) returns to idle with a
// half period of 2 ticks. A stalled result holds tick.ready low until taken.
module spi_flash_read_master #(
  parameter int ADDR_BITS = spifr_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  spifr_tick_if.sink                    tick,
  spifr_result_if.source                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spifr_pkg::PADDR_W-1:0] paddr,
  input  logic [spifr_pkg::PDATA_W-1:0] pwdata,
  output logic [spifr_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int SH_W     = 8 + ADDR_BITS;
  localparam int BITCNT_W = $clog2(SH_W + 1);
  localparam logic [BITCNT_W-1:0] SEND_BITS = BITCNT_W'(SH_W);
  localparam logic [BITCNT_W-1:0] BYTE_BITS = BITCNT_W'(8);

  // Configuration register
  logic [spifr_pkg::HALF_W-1:0] half_period;
  logic                         cfg_wr;

  // Sequencer state
  spifr_pkg::phase_t              phase, phase_next;
  logic [SH_W-1:0]                shreg, shreg_next;
  logic [BITCNT_W-1:0]            bit_count, bit_count_next;
  logic [spifr_pkg::LEN_W-1:0]    bytes_left, bytes_left_next;
  logic [7:0]                     in_shift, in_shift_next;
  logic                           clock_level, clock_level_next;
  logic [spifr_pkg::TICK_W-1:0]   tick_count, tick_count_next;

  // Tick view after a possible start
  logic                           load;
  spifr_pkg::phase_t              cur_phase;
  logic [SH_W-1:0]                cur_sh;
  logic [BITCNT_W-1:0]            cur_bc;
  logic [spifr_pkg::LEN_W-1:0]    cur_bl;
  logic [7:0]                     cur_in;
  logic                           cur_lvl;
  logic [spifr_pkg::TICK_W-1:0]   cur_tc;
  logic [spifr_pkg::HALF_W-1:0]   half_eff;
  logic                           tick_end;
  logic [BITCNT_W-1:0]            bc_inc;
  logic [7:0]                     in_new;
  logic [spifr_pkg::LEN_W-1:0]    bl_dec;

  // Result values for this tick
  logic                           r_cs_n, r_sclk, r_mosi, r_valid, r_last, r_busy;
  logic [7:0]                     r_byte;

  logic                           accept;
  logic                           res_valid;

  // APB port: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == spifr_pkg::REG_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= spifr_pkg::HALF_RESET;
    end else if (cfg_wr) begin
      half_period <= pwdata[spifr_pkg::HALF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == spifr_pkg::REG_HALF_PERIOD) begin
      prdata = spifr_pkg::PDATA_W'(half_period);
    end
  end

  // Clamp the half period to 1..16
  always_comb begin
    if (half_period == '0) begin
      half_eff = spifr_pkg::HALF_MIN;
    end else if (half_period > spifr_pkg::HALF_MAX) begin
      half_eff = spifr_pkg::HALF_MAX;
    end else begin
      half_eff = half_period;
    end
  end

  // Handshake: take a tick whenever the result register is free or draining
  assign tick.ready = !res_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  // Start while idle loads a fresh transaction for this very tick
  assign load      = (phase == spifr_pkg::PH_IDLE) && tick.start_req;
  assign cur_phase = load ? spifr_pkg::PH_SEND : phase;
  assign cur_sh    = load ? {spifr_pkg::READ_OPCODE, ADDR_BITS'(tick.address)} : shreg;
  assign cur_bc    = load ? '0 : bit_count;
  assign cur_bl    = load ? tick.length : bytes_left;
  assign cur_in    = load ? '0 : in_shift;
  assign cur_lvl   = load ? 1'b0 : clock_level;
  assign cur_tc    = load ? '0 : tick_count;

  assign tick_end = ({1'b0, cur_tc} + 5'd1) >= half_eff;
  assign bc_inc   = cur_bc + BITCNT_W'(1);
  assign in_new   = {cur_in[6:0], tick.miso};
  assign bl_dec   = (cur_bl == '0) ? '0 : cur_bl - spifr_pkg::LEN_W'(1);

  // Next state and pin levels
  always_comb begin
    phase_next       = cur_phase;
    shreg_next       = cur_sh;
    bit_count_next   = cur_bc;
    bytes_left_next  = cur_bl;
    in_shift_next    = cur_in;
    clock_level_next = cur_lvl;
    tick_count_next  = tick_end ? '0 : cur_tc + spifr_pkg::TICK_W'(1);
    r_valid          = 1'b0;
    r_byte           = '0;
    r_last           = 1'b0;
    r_cs_n           = 1'b1;
    r_sclk           = 1'b0;
    r_mosi           = 1'b0;
    r_busy           = 1'b1;

    unique case (cur_phase)
      spifr_pkg::PH_IDLE: begin
        r_busy          = 1'b0;
        tick_count_next = tick_count;
      end
      spifr_pkg::PH_DONE: begin
        if (tick_end) begin
          phase_next = spifr_pkg::PH_IDLE;
        end
      end
      spifr_pkg::PH_SEND: begin
        r_cs_n = 1'b0;
        r_sclk = cur_lvl;
        r_mosi = cur_sh[SH_W-1];
        if (tick_end) begin
          clock_level_next = !cur_lvl;
          if (cur_lvl) begin
            shreg_next     = {cur_sh[SH_W-2:0], 1'b0};
            bit_count_next = bc_inc;
            if (bc_inc >= SEND_BITS) begin
              bit_count_next = '0;
              in_shift_next  = '0;
              phase_next     = (cur_bl == '0) ? spifr_pkg::PH_DONE : spifr_pkg::PH_RECV;
            end
          end
        end
      end
      spifr_pkg::PH_RECV: begin
        r_cs_n = 1'b0;
        r_sclk = cur_lvl;
        if (tick_end) begin
          clock_level_next = !cur_lvl;
          if (cur_lvl) begin
            bit_count_next = bc_inc;
            in_shift_next  = in_new;
            if (bc_inc >= BYTE_BITS) begin
              r_valid         = 1'b1;
              r_byte          = in_new;
              r_last          = (cur_bl <= spifr_pkg::LEN_W'(1));
              bytes_left_next = bl_dec;
              bit_count_next  = '0;
              in_shift_next   = '0;
              if (bl_dec == '0) begin
                phase_next = spifr_pkg::PH_DONE;
              end
            end
          end
        end
      end
      default: begin
        phase_next = spifr_pkg::PH_IDLE;
      end
    endcase
  end

  // Advance the sequencer on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= spifr_pkg::PH_IDLE;
      shreg       <= '0;
      bit_count   <= '0;
      bytes_left  <= '0;
      in_shift    <= '0;
      clock_level <= 1'b0;
      tick_count  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      shreg       <= shreg_next;
      bit_count   <= bit_count_next;
      bytes_left  <= bytes_left_next;
      in_shift    <= in_shift_next;
      clock_level <= clock_level_next;
      tick_count  <= tick_count_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.cs_n       <= r_cs_n;
      result.sclk       <= r_sclk;
      result.mosi       <= r_mosi;
      result.byte_valid <= r_valid;
      result.read_byte  <= r_byte;
      result.last_byte  <= r_last;
      result.busy_res   <= r_busy;
    end
  end

  assign result.valid = res_valid;

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted tick produced no result");

  a_hold_without_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(tick_count) && $stable(bit_count))
    else $error("sequencer moved without an accepted tick");

  a_idle_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == spifr_pkg::PH_IDLE) && !tick.start_req
    |=> phase == spifr_pkg::PH_IDLE)
    else $error("left idle without a start");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.busy_res |-> result.cs_n && !result.sclk && !result.byte_valid)
    else $error("pins active outside a transaction");

  a_byte_only_selected: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.byte_valid |-> !result.cs_n && result.sclk)
    else $error("byte completed outside a selected high phase");
`endif

endmodule

FILE: sim/spi_flash_read_master_test.sv
`timescale 1ns / 1ps

module spi_flash_read_master_test;

  localparam int SEND_BITS = 8 + spifr_pkg::ADDR_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [spifr_pkg::PADDR_W-1:0] HALF_ADDR = {spifr_pkg::REG_HALF_PERIOD, 2'b00};
  localparam logic [spifr_pkg::PADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef enum int {MISO_RANDOM, MISO_HIGH, MISO_LOW} miso_mode_t;
  typedef enum int {FLOW_FREE, FLOW_SPARSE, FLOW_CHOPPY} flow_t;

  // Pin levels and received byte for one tick
  typedef struct packed {
    logic                         cs_n;
    logic                         sclk;
    logic                         mosi;
    logic                         byte_valid;
    logic [spifr_pkg::BYTE_W-1:0] read_byte;
    logic                         last_byte;
    logic                         busy_res;
  } pins_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [spifr_pkg::PADDR_W-1:0] paddr;
  logic [spifr_pkg::PDATA_W-1:0] pwdata;
  logic [spifr_pkg::PDATA_W-1:0] prdata;
  logic pready;

  spifr_tick_if tick_ch ();
  spifr_result_if result_ch ();

  spi_flash_read_master dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Sequencer mirror
  logic [spifr_pkg::HALF_W-1:0] half_reg = spifr_pkg::HALF_RESET;
  spifr_pkg::phase_t seq_phase = spifr_pkg::PH_IDLE;
  logic [spifr_pkg::ADDR_W-1:0] addr_reg = '0;
  logic [5:0] bit_idx = '0;
  logic [spifr_pkg::LEN_W-1:0] bytes_left = '0;
  logic [spifr_pkg::BYTE_W-1:0] rx_shift = '0;
  logic sclk_lvl = 1'b0;
  logic [spifr_pkg::TICK_W-1:0] tick_idx = '0;

  pins_t pending_pins[$];
  pins_t want_pins;
  int err_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int long_hold_req = 0;
  int hold_left = 0;
  int stretch_left = 0;
  flow_t flow_mode = FLOW_FREE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the sequencer mirror by one tick and work out its pin levels
  task automatic advance_sequencer(input logic start_bit,
                                   input logic [spifr_pkg::ADDR_W-1:0] addr,
                                   input logic [spifr_pkg::LEN_W-1:0] len,
                                   input logic miso_bit, output pins_t pins);
    int h;
    int bit_pos;
    pins = '0;
    pins.cs_n = 1'b1;
    if (seq_phase == spifr_pkg::PH_IDLE) begin
      if (!start_bit) return;
      seq_phase = spifr_pkg::PH_SEND;
      addr_reg = addr;
      bytes_left = len;
      bit_idx = '0;
      rx_shift = '0;
      sclk_lvl = 1'b0;
      tick_idx = '0;
    end
    // clamp the half period into 1..16
    h = (half_reg == 0) ? 1 :
        (half_reg > spifr_pkg::HALF_MAX) ? int'(spifr_pkg::HALF_MAX) : int'(half_reg);
    bit_pos = int'(bit_idx);
    pins.cs_n = (seq_phase == spifr_pkg::PH_DONE);
    pins.sclk = (seq_phase == spifr_pkg::PH_DONE) ? 1'b0 : sclk_lvl;
    pins.busy_res = 1'b1;
    if (seq_phase == spifr_pkg::PH_SEND) begin
      if (bit_pos < 8) pins.mosi = spifr_pkg::READ_OPCODE[7 - bit_pos];
      else if (bit_pos < SEND_BITS) pins.mosi = addr_reg[SEND_BITS - 1 - bit_pos];
    end
    if (int'(tick_idx) + 1 < h) begin
      tick_idx++;
    end else begin
      tick_idx = '0;
      if (seq_phase == spifr_pkg::PH_DONE) begin
        seq_phase = spifr_pkg::PH_IDLE;
      end else if (!sclk_lvl) begin
        sclk_lvl = 1'b1;
      end else begin
        // falling edge closes a bit
        sclk_lvl = 1'b0;
        bit_idx++;
        if (seq_phase == spifr_pkg::PH_SEND) begin
          if (int'(bit_idx) >= SEND_BITS) begin
            bit_idx = '0;
            rx_shift = '0;
            seq_phase = (bytes_left == 0) ? spifr_pkg::PH_DONE : spifr_pkg::PH_RECV;
          end
        end else begin
          rx_shift = {rx_shift[spifr_pkg::BYTE_W-2:0], miso_bit};
          if (bit_idx >= 8) begin
            pins.byte_valid = 1'b1;
            pins.read_byte = rx_shift;
            pins.last_byte = (bytes_left <= 1);
            if (bytes_left != 0) bytes_left--;
            bit_idx = '0;
            rx_shift = '0;
            if (bytes_left == 0) seq_phase = spifr_pkg::PH_DONE;
          end
        end
      end
    end
  endtask

  function automatic void check_value(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic pick_miso(miso_mode_t mode);
    case (mode)
      MISO_HIGH: return 1'b1;
      MISO_LOW: return 1'b0;
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Offer one tick item in bursts with random gaps; predict once it is taken
  task automatic send_tick(input logic start_bit, input logic [spifr_pkg::ADDR_W-1:0] addr,
                           input logic [spifr_pkg::LEN_W-1:0] len, input logic miso_bit);
    pins_t pins;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 300;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.start_req <= start_bit;
    tick_ch.address <= addr;
    tick_ch.length <= len;
    tick_ch.miso <= miso_bit;
    do @(posedge clk); while (!tick_ch.ready);
    advance_sequencer(start_bit, addr, len, miso_bit, pins);
    pending_pins.push_back(pins);
  endtask

  // Stop offering and wait until every expected result is in
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [spifr_pkg::PADDR_W-1:0] addr,
                           input logic [spifr_pkg::PDATA_W-1:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == HALF_ADDR) half_reg = data[spifr_pkg::HALF_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [spifr_pkg::PADDR_W-1:0] addr,
                          output logic [spifr_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_half_readback();
    logic [spifr_pkg::PDATA_W-1:0] value;
    apb_read(HALF_ADDR, value);
    check_value("half_period_ticks readback",
                {{(spifr_pkg::PDATA_W - spifr_pkg::HALF_W){1'b0}}, half_reg}, value);
  endtask

  task automatic set_half_period(input logic [spifr_pkg::HALF_W-1:0] value);
    apb_write(HALF_ADDR, {{(spifr_pkg::PDATA_W - spifr_pkg::HALF_W){1'b0}}, value});
    verify_half_readback();
  endtask

  // Keep ticking until the transaction ends; busy ticks may carry stray starts
  task automatic finish_read(input miso_mode_t mode, input int busy_start_pct);
    while (seq_phase != spifr_pkg::PH_IDLE)
      send_tick($urandom_range(0, 99) < busy_start_pct, spifr_pkg::ADDR_W'($urandom()),
                spifr_pkg::LEN_W'($urandom()), pick_miso(mode));
  endtask

  task automatic run_read(input logic [spifr_pkg::ADDR_W-1:0] addr,
                          input logic [spifr_pkg::LEN_W-1:0] len,
                          input miso_mode_t mode, input int busy_start_pct);
    send_tick(1'b1, addr, len, pick_miso(mode));
    finish_read(mode, busy_start_pct);
  endtask

  task automatic idle_ticks(input int count);
    repeat (count)
      send_tick(1'b0, spifr_pkg::ADDR_W'($urandom()), spifr_pkg::LEN_W'($urandom()),
                1'($urandom_range(0, 1)));
  endtask

  // Ticks with random start bits, for use while a transaction runs
  task automatic stray_ticks(input int count);
    repeat (count)
      send_tick(1'($urandom_range(0, 1)), spifr_pkg::ADDR_W'($urandom()),
                spifr_pkg::LEN_W'($urandom()), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_idle_after_reset();
    verify_half_readback();
    send_tick(1'b0, '1, '1, 1'b1);
    send_tick(1'b0, '0, '0, 1'b0);
    idle_ticks(10);
  endtask

  task automatic test_opcode_and_address();
    // a one-tick half period keeps each transaction short
    set_half_period(5'd1);
    run_read(24'hFFFFFF, 8'd1, MISO_HIGH, 0);
    run_read(24'h000000, 8'd1, MISO_LOW, 0);
  endtask

  task automatic test_zero_length();
    // starts also arrive through the closing half period
    run_read(24'h5AA5C3, 8'd0, MISO_RANDOM, 100);
    idle_ticks(3);
  endtask

  task automatic test_start_while_busy();
    // every busy tick, the closing half period included, asks for a new start
    run_read(spifr_pkg::ADDR_W'($urandom()), 8'd1, MISO_RANDOM, 100);
  endtask

  task automatic test_half_period_limits();
    // values above 16 hold each level for 16 ticks
    set_half_period(5'd17);
    send_tick(1'b1, spifr_pkg::ADDR_W'($urandom()), 8'd1, pick_miso(MISO_RANDOM));
    stray_ticks(34);
    set_half_period(5'd31);
    stray_ticks(34);
    // zero runs as a one-tick half period
    set_half_period(5'd0);
    finish_read(MISO_RANDOM, 20);
  endtask

  task automatic test_half_change_midway();
    // shrink the half period while a level has already outlasted it
    set_half_period(5'd8);
    send_tick(1'b1, spifr_pkg::ADDR_W'($urandom()), 8'd1, pick_miso(MISO_RANDOM));
    stray_ticks(11);
    set_half_period(5'd3);
    stray_ticks(5);
    // stretch it mid-level, then bring it back
    set_half_period(5'd6);
    stray_ticks(10);
    set_half_period(5'd1);
    finish_read(MISO_RANDOM, 20);
  endtask

  task automatic test_spare_register();
    apb_write(SPARE_ADDR, 32'h0000_001F);
    verify_half_readback();
    idle_ticks(3);
  endtask

  task automatic test_output_stall();
    set_half_period(5'd1);
    long_hold_req = 400;
    run_read(spifr_pkg::ADDR_W'($urandom()), 8'd2, MISO_RANDOM, 10);
  endtask

  task automatic test_random_reads();
    logic [spifr_pkg::HALF_W-1:0] halves[2] = '{5'd2, 5'd1};
    foreach (halves[i]) begin
      set_half_period(halves[i]);
      idle_ticks($urandom_range(0, 5));
      run_read(spifr_pkg::ADDR_W'($urandom()), spifr_pkg::LEN_W'($urandom_range(0, 2)),
               MISO_RANDOM, $urandom_range(0, 50));
    end
  endtask

  // Receiver: stretches of free flow and stalls, plus a requested long hold
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (long_hold_req > 0) begin
        hold_left = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(5, 80);
          flow_mode = flow_t'($urandom_range(0, 2));
        end
        stretch_left--;
        case (flow_mode)
          FLOW_FREE: result_ch.ready <= 1'b1;
          FLOW_SPARSE: result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Compare each taken result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_pins.size() == 0) begin
        err_count++;
        $display("%0t: result item with nothing expected, expected none, actual cs_n=%0b",
                 $time, result_ch.cs_n);
      end else begin
        want_pins = pending_pins.pop_front();
        check_value("cs_n", want_pins.cs_n, result_ch.cs_n);
        check_value("sclk", want_pins.sclk, result_ch.sclk);
        check_value("mosi", want_pins.mosi, result_ch.mosi);
        check_value("byte_valid", want_pins.byte_valid, result_ch.byte_valid);
        check_value("read_byte", want_pins.read_byte, result_ch.read_byte);
        check_value("last_byte", want_pins.last_byte, result_ch.last_byte);
        check_value("busy_res", want_pins.busy_res, result_ch.busy_res);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_pins.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    tick_ch.valid <= 1'b0;
    tick_ch.start_req <= 1'b0;
    tick_ch.address <= '0;
    tick_ch.length <= '0;
    tick_ch.miso <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_after_reset();
    test_opcode_and_address();
    test_zero_length();
    test_start_while_busy();
    test_half_period_limits();
    test_half_change_midway();
    test_spare_register();
    test_output_stall();
    test_random_reads();

    drain();
    repeat (4) @(posedge clk);
    if (pending_pins.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_pins.size());
    end
    if (err_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
